/* hdl/mlrd_pkg.sv */
// Shared constants, codes and the queue entry type of the record deframer.
package mlrd_pkg;

    localparam int HDR_LEN = 8;
    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = $clog2(QDEPTH);

    localparam logic [7:0] MAGIC_HI = 8'hA5;
    localparam logic [7:0] MAGIC_LO = 8'h5A;

    // Result kinds.
    localparam logic [1:0] K_BYTE   = 2'd0;
    localparam logic [1:0] K_FINISH = 2'd1;
    localparam logic [1:0] K_ERROR  = 2'd2;

    // Error codes.
    localparam logic [2:0] E_NONE        = 3'd0;
    localparam logic [2:0] E_EMPTY       = 3'd1;
    localparam logic [2:0] E_MAGIC_START = 3'd2;
    localparam logic [2:0] E_MAGIC_LATER = 3'd3;
    localparam logic [2:0] E_LENGTH      = 3'd4;

    // One queue entry: up to eight record bytes, then an optional closing result.
    // A tail kind of K_BYTE means that no closing result follows the bytes.
    typedef struct packed {
        logic [3:0]  nbytes;
        logic [63:0] data;
        logic [31:0] index;
        logic        eor;
        logic [1:0]  tail_kind;
        logic [2:0]  code;
        logic [31:0] offset;
        logic [31:0] count;
    } t_qent;

endpackage

/* hdl/mlrd_front.sv */
// Front end: accepts requests, tracks the framing state and queues result work.
module mlrd_front import mlrd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [31:0] i_total_length,
    input  logic        i_valid,
    input  logic        i_cmd,
    input  logic [7:0]  i_data_byte,
    input  logic        i_q_full,
    output logic        o_push,
    output t_qent       o_ent
);

    localparam logic [1:0] PH_IDLE   = 2'd0;
    localparam logic [1:0] PH_HEADER = 2'd1;
    localparam logic [1:0] PH_BODY   = 2'd2;
    localparam logic [1:0] PH_DONE   = 2'd3;

    logic [1:0]  r_phase,  n_phase;
    logic [31:0] r_offset, n_offset;
    logic [31:0] r_start,  n_start;
    logic [2:0]  r_fill,   n_fill;
    logic [31:0] r_left,   n_left;
    logic [31:0] r_done,   n_done;
    logic [7:0]  r_hdr [0:6];

    logic        w_accept;
    logic [32:0] w_rem_diff;
    logic [31:0] w_rem;
    logic [31:0] w_len;
    logic [31:0] w_off1;
    logic [32:0] w_end_diff;
    logic [7:0]  w_magic;
    logic [2:0]  w_mcode;

    assign w_accept   = i_valid && !i_q_full;
    assign w_rem_diff = {1'b0, i_total_length} - {1'b0, r_start};
    assign w_rem      = (w_rem_diff[32] || (w_rem_diff == '0)) ? '0 : w_rem_diff[31:0];
    assign w_len      = {i_data_byte, r_hdr[6], r_hdr[5], r_hdr[4]};
    assign w_off1     = r_offset + 32'd1;
    assign w_end_diff = {1'b0, i_total_length} - {1'b0, w_off1};
    assign w_magic    = r_fill[1] ? MAGIC_LO : MAGIC_HI;
    assign w_mcode    = (r_start == '0) ? E_MAGIC_START : E_MAGIC_LATER;

    always_comb begin
        n_phase  = r_phase;
        n_offset = r_offset;
        n_start  = r_start;
        n_fill   = r_fill;
        n_left   = r_left;
        n_done   = r_done;
        o_push   = 1'b0;
        o_ent    = '0;
        if (w_accept) begin
            if (i_cmd) begin
                n_offset = '0;
                n_start  = '0;
                n_fill   = '0;
                n_left   = '0;
                n_done   = '0;
                n_phase  = PH_HEADER;
                if (i_total_length == '0) begin
                    o_push          = 1'b1;
                    o_ent.tail_kind = K_ERROR;
                    o_ent.code      = E_EMPTY;
                    n_phase         = PH_DONE;
                end else if (i_total_length < 32'(HDR_LEN)) begin
                    o_push          = 1'b1;
                    o_ent.tail_kind = K_ERROR;
                    o_ent.code      = E_MAGIC_START;
                    n_phase         = PH_DONE;
                end
            end else begin
                case (r_phase)
                    PH_HEADER: begin
                        n_fill   = r_fill + 3'd1;
                        n_offset = w_off1;
                        o_ent.count  = r_done;
                        o_ent.offset = r_start;
                        if (!r_fill[2] && (i_data_byte != w_magic)) begin
                            o_push          = 1'b1;
                            o_ent.tail_kind = K_ERROR;
                            o_ent.code      = w_mcode;
                            n_phase         = PH_DONE;
                        end else if (r_fill == 3'd7) begin
                            o_push = 1'b1;
                            if (w_rem < 32'(HDR_LEN)) begin
                                o_ent.tail_kind = K_ERROR;
                                o_ent.code      = w_mcode;
                                n_phase         = PH_DONE;
                            end else if ((w_len <= 32'(HDR_LEN)) || (w_len > w_rem)) begin
                                o_ent.tail_kind = K_ERROR;
                                o_ent.code      = E_LENGTH;
                                n_phase         = PH_DONE;
                            end else begin
                                // Header is good: release all eight bytes at once.
                                o_ent.nbytes = 4'(HDR_LEN);
                                o_ent.data   = {i_data_byte, r_hdr[6], r_hdr[5], r_hdr[4],
                                                r_hdr[3], r_hdr[2], r_hdr[1], r_hdr[0]};
                                o_ent.index  = r_done;
                                o_ent.offset = '0;
                                o_ent.count  = '0;
                                n_left       = w_len - 32'(HDR_LEN);
                                n_fill       = '0;
                                n_phase      = PH_BODY;
                            end
                        end
                    end
                    PH_BODY: begin
                        n_offset     = w_off1;
                        n_left       = r_left - 32'd1;
                        o_push       = 1'b1;
                        o_ent.nbytes = 4'd1;
                        o_ent.data   = {56'd0, i_data_byte};
                        o_ent.index  = r_done;
                        if (r_left == 32'd1) begin
                            o_ent.eor   = 1'b1;
                            o_ent.count = r_done + 32'd1;
                            n_done      = r_done + 32'd1;
                            n_fill      = '0;
                            if (w_end_diff[32] || (w_end_diff == '0)) begin
                                o_ent.tail_kind = K_FINISH;
                                n_phase         = PH_DONE;
                            end else if (w_end_diff < 33'(HDR_LEN)) begin
                                o_ent.tail_kind = K_ERROR;
                                o_ent.code      = (w_off1 == '0) ? E_MAGIC_START
                                                                 : E_MAGIC_LATER;
                                o_ent.offset    = w_off1;
                                n_phase         = PH_DONE;
                            end else begin
                                n_start = w_off1;
                                n_phase = PH_HEADER;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_offset <= '0;
            r_start  <= '0;
            r_fill   <= '0;
            r_left   <= '0;
            r_done   <= '0;
        end else begin
            r_phase  <= n_phase;
            r_offset <= n_offset;
            r_start  <= n_start;
            r_fill   <= n_fill;
            r_left   <= n_left;
            r_done   <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && !i_cmd && (r_phase == PH_HEADER) && (r_fill != 3'd7)) begin
            r_hdr[r_fill] <= i_data_byte;
        end
    end

    // A record body always has at least one byte still to come.
    a_body_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_BODY) |-> (r_left != '0))
        else $error("body phase with no bytes left");

endmodule

/* hdl/mlrd_queue.sv */
// Short queue of work entries between the front end and the result sequencer.
module mlrd_queue import mlrd_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_qent i_ent,
    input  logic  i_pop,
    output logic  o_full,
    output logic  o_valid,
    output t_qent o_head
);

    t_qent             r_mem [0:QDEPTH-1];
    logic [QPTR_W-1:0] r_wp, r_rp;
    logic [QPTR_W:0]   r_cnt;
    logic              w_do_pop;

    assign o_full   = (r_cnt == (QPTR_W+1)'(QDEPTH));
    assign o_valid  = (r_cnt != '0);
    assign o_head   = r_mem[r_rp];
    assign w_do_pop = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == QPTR_W'(QDEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (w_do_pop) begin
                r_rp <= (r_rp == QPTR_W'(QDEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (i_push && !w_do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && w_do_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_ent;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into a full queue");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (QPTR_W+1)'(QDEPTH))
        else $error("queue count out of range");

endmodule

/* hdl/mlrd_back.sv */
// Back end: expands queue entries into result items and holds the output register.
module mlrd_back import mlrd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_q_valid,
    input  t_qent       i_q_head,
    output logic        o_pop,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_record_byte,
    output logic [31:0] o_record_index,
    output logic        o_end_of_record,
    output logic [2:0]  o_error_code,
    output logic [31:0] o_error_offset,
    output logic [31:0] o_record_count,
    output logic        o_last_result
);

    logic        r_cur_valid;
    t_qent       r_cur;
    logic [3:0]  r_step;

    logic        w_free;
    logic        w_has_tail;
    logic        w_is_byte;
    logic        w_last;
    logic        w_emit;
    logic        w_fetch;

    assign w_free     = !o_out_valid || !i_out_stall;
    assign w_has_tail = (r_cur.tail_kind != K_BYTE);
    assign w_is_byte  = (r_step < r_cur.nbytes);
    assign w_last     = w_is_byte ? ((r_step == (r_cur.nbytes - 4'd1)) && !w_has_tail) : 1'b1;
    assign w_emit     = r_cur_valid && w_free;
    assign w_fetch    = !r_cur_valid || (w_emit && w_last);
    assign o_pop      = w_fetch && i_q_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_valid <= 1'b0;
            r_step      <= '0;
            o_out_valid <= 1'b0;
        end else begin
            if (w_fetch) begin
                r_cur_valid <= i_q_valid;
                r_step      <= '0;
            end else if (w_emit) begin
                r_step <= r_step + 4'd1;
            end
            if (w_emit) begin
                o_out_valid <= 1'b1;
            end else if (w_free) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fetch) begin
            r_cur <= i_q_head;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            o_last_result <= w_last;
            if (w_is_byte) begin
                o_kind          <= K_BYTE;
                o_record_byte   <= r_cur.data[r_step[2:0]*8 +: 8];
                o_record_index  <= r_cur.index;
                o_end_of_record <= r_cur.eor;
                o_error_code    <= E_NONE;
                o_error_offset  <= '0;
                o_record_count  <= '0;
            end else begin
                o_kind          <= r_cur.tail_kind;
                o_record_byte   <= '0;
                o_record_index  <= '0;
                o_end_of_record <= 1'b0;
                o_error_code    <= r_cur.code;
                o_error_offset  <= r_cur.offset;
                o_record_count  <= r_cur.count;
            end
        end
    end

    // The step counter never runs past the closing result of an entry.
    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cur_valid |-> (r_step <= r_cur.nbytes))
        else $error("result step past end of entry");

endmodule

/* hdl/magic_length_record_deframer.sv */
// Top level of the magic and length prefixed record deframer.
//
// Usage: load total_length through i_cfg_wr_en / i_cfg_wr_data while the block
// is idle, then send a start request (i_cmd = 1) followed by the stream bytes
// (i_cmd = 0). A request is taken on a clock edge where i_in_valid is high and
// o_in_stall is low; a result is taken where o_out_valid is high and i_out_stall
// is low. Each record's eight header bytes are held back until the header has
// been checked, then released as eight results; body bytes pass one per request.
// A finished or error result closes the stream, and o_last_result marks the
// final result produced by each request.
//
// A request's results are queued as a work entry, loaded into the back end and
// then registered at the output. Throughput: one request per cycle while the
// queue is not full, one result per cycle while the receiver does not stall.
// A good header expands into eight results, so the four-entry work queue fills
// in that burst and o_in_stall rises; the back end's single result port sets the rate.
// Reset (synchronous, active low) empties the queue and output register, returns
// the framer to idle and clears total_length. When the receiver stalls, the held
// result stays put, the queue fills, and then requests are stalled in turn.
module magic_length_record_deframer import mlrd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [31:0] i_cfg_wr_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_cmd,
    input  logic [7:0]  i_data_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_record_byte,
    output logic [31:0] o_record_index,
    output logic        o_end_of_record,
    output logic [2:0]  o_error_code,
    output logic [31:0] o_error_offset,
    output logic [31:0] o_record_count,
    output logic        o_last_result
);

    logic [31:0] r_total_length;
    logic        w_push;
    t_qent       w_push_ent;
    logic        w_q_full;
    logic        w_q_valid;
    t_qent       w_q_head;
    logic        w_pop;

    // The buffer length register; the user must write it only between streams, which the block does not enforce.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total_length <= '0;
        end else if (i_cfg_wr_en) begin
            r_total_length <= i_cfg_wr_data;
        end
    end

    // Requests are held off only while the work queue is full.
    assign o_in_stall = w_q_full;

    mlrd_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_total_length (r_total_length),
        .i_valid        (i_in_valid),
        .i_cmd          (i_cmd),
        .i_data_byte    (i_data_byte),
        .i_q_full       (w_q_full),
        .o_push         (w_push),
        .o_ent          (w_push_ent)
    );

    mlrd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_ent   (w_push_ent),
        .i_pop   (w_pop),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .o_head  (w_q_head)
    );

    mlrd_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_valid       (w_q_valid),
        .i_q_head        (w_q_head),
        .o_pop           (w_pop),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_kind          (o_kind),
        .o_record_byte   (o_record_byte),
        .o_record_index  (o_record_index),
        .o_end_of_record (o_end_of_record),
        .o_error_code    (o_error_code),
        .o_error_offset  (o_error_offset),
        .o_record_count  (o_record_count),
        .o_last_result   (o_last_result)
    );

endmodule
